// File: hdl/assert_macros.svh
// assertion macros used by the rtl framer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/dlrv_pkg.sv
// types and constants of the dependency log record validator
`timescale 1ns / 1ps

package dlrv_pkg;

   // widths of the beat fields
   localparam int WORD_W      = 32;
   localparam int ID_W        = 31;
   localparam int SIZE_W      = 31;
   localparam int REC_W       = SIZE_W - 2;
   localparam int STATUS_W    = 3;
   localparam int VW_OUT_W    = 28;
   localparam int CNT_W       = 17;
   localparam int TIME_W      = 64;

   // valid word counter width and saturation limit
   localparam int LOG_WORDS_BITS = 28;
   localparam int SUM_W = ((LOG_WORDS_BITS > REC_W) ? LOG_WORDS_BITS : REC_W) + 1;
   localparam logic [LOG_WORDS_BITS-1:0] VW_LIMIT = '1;

   localparam logic [ID_W-1:0]  ID_MAX     = '1;
   localparam logic [CNT_W-1:0] CNT_MAX    = '1;
   localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = SIZE_W'(524287);

   // minimum payload words per record kind
   localparam logic [REC_W-1:0] PATH_MIN_WORDS = REC_W'(2);
   localparam logic [REC_W-1:0] DEPS_MIN_WORDS = REC_W'(3);
   localparam logic [REC_W-1:0] DEPS_FIXED_WORDS = REC_W'(3);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSIDE  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PATH    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEPS    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

   // record parsing phase, one-hot
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_PATH   = 6'b000010,
      PH_DOUT   = 6'b000100,
      PH_DTLO   = 6'b001000,
      PH_DTHI   = 6'b010000,
      PH_DIN    = 6'b100000
   } phase_type;

   // one input beat
   typedef struct packed {
      logic [WORD_W-1:0] log_word;
      logic              final_word;
   } word_beat_type;

endpackage

// File: hdl/dep_log_record_validator.sv
// top level of the dependency log record validator
`timescale 1ns / 1ps

// Frames a dependency log body, one 32-bit word per beat, into path and
// dependency records and returns one result beat for every word. Each word
// passes an input register and then the framer, whose checks (header size,
// path checksum, id bounds) are a few compares and small counters, so a new
// word is taken every cycle while the result side is not stalled; its result
// beat is held in the framer's result register until rsp_ready takes it.
// req_ready follows rsp_ready within the same cycle through both stages. A
// beat with final_word set ends the log and returns the framing state to
// reset; the max_record_bytes register keeps its value. The register is
// written through the csr channel, which is always ready; write it only while
// no word is in flight, as the block itself does not enforce this.

module dep_log_record_validator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dlrv_pkg::SIZE_W-1:0]         csr_max_record_bytes,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dlrv_pkg::WORD_W-1:0]         req_log_word,
   input  logic                                req_final_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dlrv_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dlrv_pkg::VW_OUT_W-1:0]       rsp_valid_words,
   output logic [dlrv_pkg::ID_W-1:0]           rsp_node_total,
   output logic [dlrv_pkg::ID_W-1:0]           rsp_output_node,
   output logic [dlrv_pkg::TIME_W-1:0]         rsp_record_time,
   output logic [dlrv_pkg::CNT_W-1:0]          rsp_input_count
);

   logic [dlrv_pkg::SIZE_W-1:0]  max_bytes_ff;
   dlrv_pkg::word_beat_type      req_beat;
   dlrv_pkg::word_beat_type      beat;
   logic                         beat_valid;
   logic                         beat_ready;

   // size limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= dlrv_pkg::MAX_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         max_bytes_ff <= csr_max_record_bytes;
      end
   end

   // gather the request fields into one beat
   always_comb begin
      req_beat.log_word   = req_log_word;
      req_beat.final_word = req_final_word;
   end

   dlrv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   dlrv_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .max_record_bytes (max_bytes_ff),
      .beat_valid       (beat_valid),
      .beat_ready       (beat_ready),
      .beat             (beat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_valid_words  (rsp_valid_words),
      .rsp_node_total   (rsp_node_total),
      .rsp_output_node  (rsp_output_node),
      .rsp_record_time  (rsp_record_time),
      .rsp_input_count  (rsp_input_count)
   );

endmodule

// File: hdl/dlrv_in_reg.sv
// input register stage holding one log word beat
`timescale 1ns / 1ps

module dlrv_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dlrv_pkg::word_beat_type req_beat,
   output logic                   beat_valid,
   input  logic                   beat_ready,
   output dlrv_pkg::word_beat_type beat
);

   logic                    valid_ff;
   logic                    valid_in;
   dlrv_pkg::word_beat_type beat_ff;
   logic                    load;

   // take a beat when empty or when the held one moves on
   assign req_ready = !valid_ff || beat_ready;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (beat_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// File: hdl/dlrv_framer.sv
// record framing state, per-word checks and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlrv_framer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [dlrv_pkg::SIZE_W-1:0]            max_record_bytes,
   input  logic                                   beat_valid,
   output logic                                   beat_ready,
   input  dlrv_pkg::word_beat_type                beat,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dlrv_pkg::STATUS_W-1:0]          rsp_status,
   output logic [dlrv_pkg::VW_OUT_W-1:0]          rsp_valid_words,
   output logic [dlrv_pkg::ID_W-1:0]              rsp_node_total,
   output logic [dlrv_pkg::ID_W-1:0]              rsp_output_node,
   output logic [dlrv_pkg::TIME_W-1:0]            rsp_record_time,
   output logic [dlrv_pkg::CNT_W-1:0]             rsp_input_count
);

   // framing state
   dlrv_pkg::phase_type                   phase_ff, phase_in;
   logic [dlrv_pkg::REC_W-1:0]            words_left_ff, words_left_in;
   logic [dlrv_pkg::ID_W-1:0]             next_node_ff, next_node_in;
   logic [dlrv_pkg::LOG_WORDS_BITS-1:0]   valid_total_ff, valid_total_in;
   logic [dlrv_pkg::REC_W-1:0]            record_words_ff, record_words_in;
   logic [dlrv_pkg::ID_W-1:0]             held_output_ff, held_output_in;
   logic [dlrv_pkg::WORD_W-1:0]           held_time_low_ff, held_time_low_in;
   logic                                  stopped_ff, stopped_in;

   // result register
   logic                                  rsp_valid_ff;
   logic [dlrv_pkg::STATUS_W-1:0]         status_ff, status_in;
   logic [dlrv_pkg::VW_OUT_W-1:0]         valid_words_ff;
   logic [dlrv_pkg::ID_W-1:0]             node_total_ff;
   logic [dlrv_pkg::ID_W-1:0]             output_node_ff, output_node_in;
   logic [dlrv_pkg::TIME_W-1:0]           record_time_ff, record_time_in;
   logic [dlrv_pkg::CNT_W-1:0]            input_count_ff, input_count_in;

   // per-beat working signals
   logic                                  fire;
   logic                                  last;
   logic                                  accept;
   logic                                  deps_hdr;
   logic                                  bad_hdr;
   logic [dlrv_pkg::SIZE_W-1:0]           raw_bytes;
   logic [dlrv_pkg::REC_W-1:0]            body_words;
   logic [dlrv_pkg::REC_W-1:0]            in_ids;
   logic [dlrv_pkg::WORD_W-1:0]           node_limit;
   logic [dlrv_pkg::SUM_W-1:0]            vw_sum;
   logic [dlrv_pkg::SUM_W-1:0]            vw_wide;

   // the result register frees up when empty or taken
   assign beat_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = beat_valid && beat_ready;

   assign raw_bytes  = beat.log_word[dlrv_pkg::SIZE_W-1:0];
   assign body_words = raw_bytes[dlrv_pkg::SIZE_W-1:2];
   assign deps_hdr   = beat.log_word[dlrv_pkg::WORD_W-1];
   assign node_limit = {1'b0, next_node_ff};
   assign last       = (words_left_ff <= dlrv_pkg::REC_W'(1));
   assign in_ids     = record_words_ff - dlrv_pkg::DEPS_FIXED_WORDS;
   assign vw_sum     = dlrv_pkg::SUM_W'(valid_total_ff)
                       + dlrv_pkg::SUM_W'(record_words_ff)
                       + dlrv_pkg::SUM_W'(1);

   // header checks: alignment, limit, minimum size, no final beat
   always_comb begin
      bad_hdr = (raw_bytes[1:0] != 2'b00) || (raw_bytes > max_record_bytes)
                || beat.final_word;
      if (deps_hdr) begin
         bad_hdr = bad_hdr || (body_words < dlrv_pkg::DEPS_MIN_WORDS);
      end else begin
         bad_hdr = bad_hdr || (body_words < dlrv_pkg::PATH_MIN_WORDS);
      end
   end

   // next state and result for one beat
   always_comb begin
      phase_in         = phase_ff;
      words_left_in    = words_left_ff;
      next_node_in     = next_node_ff;
      valid_total_in   = valid_total_ff;
      record_words_in  = record_words_ff;
      held_output_in   = held_output_ff;
      held_time_low_in = held_time_low_ff;
      stopped_in       = stopped_ff;
      status_in        = dlrv_pkg::ST_INSIDE;
      output_node_in   = '0;
      record_time_in   = '0;
      input_count_in   = '0;
      accept           = 1'b0;

      if (stopped_ff) begin
         status_in = dlrv_pkg::ST_IGNORED;
      end else if (phase_ff == dlrv_pkg::PH_HEADER) begin
         if (bad_hdr) begin
            status_in = dlrv_pkg::ST_INVALID;
         end else begin
            record_words_in = body_words;
            words_left_in   = body_words;
            phase_in        = deps_hdr ? dlrv_pkg::PH_DOUT : dlrv_pkg::PH_PATH;
         end
      end else begin
         words_left_in = last ? '0 : (words_left_ff - dlrv_pkg::REC_W'(1));
         case (phase_ff)
            dlrv_pkg::PH_PATH: begin
               // checksum is the complement of the next node id
               if (last) begin
                  if (beat.log_word == ~node_limit) begin
                     if (next_node_ff != dlrv_pkg::ID_MAX) begin
                        next_node_in = next_node_ff + dlrv_pkg::ID_W'(1);
                     end
                     accept    = 1'b1;
                     status_in = dlrv_pkg::ST_PATH;
                  end else begin
                     status_in = dlrv_pkg::ST_INVALID;
                  end
               end
            end
            dlrv_pkg::PH_DOUT: begin
               if (beat.log_word >= node_limit) begin
                  status_in = dlrv_pkg::ST_INVALID;
               end else begin
                  held_output_in = beat.log_word[dlrv_pkg::ID_W-1:0];
                  phase_in       = dlrv_pkg::PH_DTLO;
               end
            end
            dlrv_pkg::PH_DTLO: begin
               held_time_low_in = beat.log_word;
               phase_in         = dlrv_pkg::PH_DTHI;
            end
            dlrv_pkg::PH_DTHI: begin
               record_time_in = {beat.log_word, held_time_low_ff};
               phase_in       = dlrv_pkg::PH_DIN;
            end
            dlrv_pkg::PH_DIN: begin
               if (beat.log_word >= node_limit) begin
                  status_in = dlrv_pkg::ST_INVALID;
               end
            end
            default: begin
               status_in = dlrv_pkg::ST_INSIDE;
            end
         endcase

         // deps record completes on its last word; otherwise final means truncation
         if ((status_in != dlrv_pkg::ST_INVALID) && last
             && (phase_in == dlrv_pkg::PH_DIN)) begin
            output_node_in = held_output_ff;
            if (in_ids > dlrv_pkg::REC_W'(dlrv_pkg::CNT_MAX)) begin
               input_count_in = dlrv_pkg::CNT_MAX;
            end else begin
               input_count_in = in_ids[dlrv_pkg::CNT_W-1:0];
            end
            accept    = 1'b1;
            status_in = dlrv_pkg::ST_DEPS;
         end else if ((status_in != dlrv_pkg::ST_INVALID)
                      && (status_in != dlrv_pkg::ST_PATH) && beat.final_word) begin
            status_in = dlrv_pkg::ST_INVALID;
         end
         if (status_in != dlrv_pkg::ST_DEPS) begin
            record_time_in = '0;
         end
      end

      // saturating count of words in valid records
      if (accept) begin
         if (vw_sum > dlrv_pkg::SUM_W'(dlrv_pkg::VW_LIMIT)) begin
            valid_total_in = dlrv_pkg::VW_LIMIT;
         end else begin
            valid_total_in = vw_sum[dlrv_pkg::LOG_WORDS_BITS-1:0];
         end
         phase_in = dlrv_pkg::PH_HEADER;
      end

      if (status_in == dlrv_pkg::ST_INVALID) begin
         stopped_in = 1'b1;
      end
   end

   assign vw_wide = dlrv_pkg::SUM_W'(valid_total_in);

   // state update; the final beat returns everything to reset
   always_ff @(posedge clock) begin
      if (reset || (fire && beat.final_word)) begin
         phase_ff         <= dlrv_pkg::PH_HEADER;
         words_left_ff    <= '0;
         next_node_ff     <= '0;
         valid_total_ff   <= '0;
         record_words_ff  <= '0;
         held_output_ff   <= '0;
         held_time_low_ff <= '0;
         stopped_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         words_left_ff    <= words_left_in;
         next_node_ff     <= next_node_in;
         valid_total_ff   <= valid_total_in;
         record_words_ff  <= record_words_in;
         held_output_ff   <= held_output_in;
         held_time_low_ff <= held_time_low_in;
         stopped_ff       <= stopped_in;
      end
   end

   // result beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff      <= status_in;
         valid_words_ff <= vw_wide[dlrv_pkg::VW_OUT_W-1:0];
         node_total_ff  <= next_node_in;
         output_node_ff <= output_node_in;
         record_time_ff <= record_time_in;
         input_count_ff <= input_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_valid_words = valid_words_ff;
   assign rsp_node_total  = node_total_ff;
   assign rsp_output_node = output_node_ff;
   assign rsp_record_time = record_time_ff;
   assign rsp_input_count = input_count_ff;

   // once stopped, every beat is ignored
   `AST_NEXT(a_stopped_ignores, clock, reset, fire && stopped_ff, status_ff == dlrv_pkg::ST_IGNORED)
   // an invalid beat that is not the last stops the framer
   `AST_NEXT(a_invalid_stops, clock, reset, fire && !beat.final_word && (status_in == dlrv_pkg::ST_INVALID), stopped_ff)
   // record details only ride on an accepted deps record
   `AST_IMPLY(a_deps_fields, clock, reset, rsp_valid_ff && (status_ff != dlrv_pkg::ST_DEPS), (output_node_ff == '0) && (record_time_ff == '0) && (input_count_ff == '0))
   // the final beat clears the framing state
   `AST_NEXT(a_final_clears, clock, reset, fire && beat.final_word, (phase_ff == dlrv_pkg::PH_HEADER) && !stopped_ff && (next_node_ff == '0) && (valid_total_ff == '0))

endmodule
